/* rtl/core/hcbp_pkg.sv */
// Package for the code bit packer: widths, operation codes and the result type.
// No dependencies; every other file of the block takes its names from here.
package hcbp_pkg;

   // Table geometry
   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int ADDR_W       = $clog2(SYMBOL_COUNT);

   // Item field widths
   localparam int OP_W   = 2;
   localparam int SYM_W  = 8;
   localparam int CODE_W = 16;
   localparam int LEN_W  = 5;
   localparam int BYTE_W = 8;
   localparam int PAD_W  = 4;

   localparam int CODE_LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   // Pending bits and bit accumulator
   localparam int PEND_W    = BYTE_W - 1;
   localparam int PCNT_W    = $clog2(BYTE_W);
   localparam int ACC_W     = PEND_W + CODE_W;
   localparam int TOTAL_W   = $clog2(ACC_W + 1);
   localparam int ENTRY_W   = LEN_W + CODE_W;

   // Result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic [PAD_W-1:0]  pad_count;
      logic              last_of_run;
      logic              unknown_symbol;
   } result_type;

endpackage

/* rtl/core/hcbp_req_if.sv */
// Input channel of the code bit packer: valid/ready handshake and request fields.
// Depends on hcbp_pkg for the field widths.
interface hcbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [hcbp_pkg::OP_W-1:0]    operation;
   logic [hcbp_pkg::SYM_W-1:0]   symbol;
   logic [hcbp_pkg::CODE_W-1:0]  code_value;
   logic [hcbp_pkg::LEN_W-1:0]   code_length;

   modport source (output valid, operation, symbol, code_value, code_length, input ready);
   modport sink   (input valid, operation, symbol, code_value, code_length, output ready);
endinterface

/* rtl/core/hcbp_rsp_if.sv */
// Result channel of the code bit packer: valid/ready handshake and result fields.
// Depends on hcbp_pkg for the field widths.
interface hcbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hcbp_pkg::BYTE_W-1:0]  byte_value;
   logic [hcbp_pkg::PAD_W-1:0]   pad_count;
   logic                         last_of_run;
   logic                         unknown_symbol;

   modport source (output valid, byte_value, pad_count, last_of_run, unknown_symbol,
                   input ready);
   modport sink   (input valid, byte_value, pad_count, last_of_run, unknown_symbol,
                   output ready);
endinterface

/* rtl/core/huffman_code_bit_packer_top.sv */
// Code bit packer: registered table read, pack stage, result queue. Throughput:
// one item per cycle while the queue has room for two results each from the
// staged and the new item; two-byte items are bounded by rsp drain rate.
// Reset (synchronous): marks all table entries invalid, clears pending bits,
// the pack stage and the result queue; no clearing pass is needed.
module huffman_code_bit_packer_top (
   input logic        clock,
   input logic        reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   // ------------------------------------------------------------------
   // Table storage: code memory with registered read, valid bits in flops
   // ------------------------------------------------------------------
   logic [hcbp_pkg::ENTRY_W-1:0]      code_mem [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::SYMBOL_COUNT-1:0] entry_valid_ff;
   logic [hcbp_pkg::ENTRY_W-1:0]      mem_rd_ff;

   // Pack stage registers
   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   hcbp_pkg::op_type                  s1_op_ff;
   logic                              s1_hit_ff;

   // Pending bit accumulator
   logic [hcbp_pkg::PEND_W-1:0]       pend_bits_ff, pend_bits_in;
   logic [hcbp_pkg::PCNT_W-1:0]       pend_cnt_ff, pend_cnt_in;

   // Result queue
   hcbp_pkg::result_type              queue_ff [hcbp_pkg::QUEUE_DEPTH];
   logic [hcbp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::QCNT_W-1:0]       count_ff, count_in;

   // Request decode
   logic                              req_accept;
   hcbp_pkg::op_type                  req_op;
   logic                              sym_in_range;
   logic [hcbp_pkg::ADDR_W-1:0]       req_addr;
   logic [hcbp_pkg::LEN_W-1:0]        load_len;
   logic [hcbp_pkg::CODE_W-1:0]       load_code;
   logic [hcbp_pkg::QCNT_W:0]         space_need;

   // Pack stage results
   logic [1:0]                        push_n;
   hcbp_pkg::result_type              push0, push1;
   logic                              pop;

   assign req_op       = hcbp_pkg::op_type'(req_chan.operation);
   assign req_addr     = hcbp_pkg::ADDR_W'(req_chan.symbol);
   assign sym_in_range = (32'(req_chan.symbol) < hcbp_pkg::SYMBOL_COUNT);
   assign req_accept   = req_chan.valid && req_chan.ready;

   // Admit an item only when the queue can take the worst case of the
   // item in the pack stage plus this one (two results each).
   always_comb begin
      space_need = {1'b0, count_ff} + (hcbp_pkg::QCNT_W+1)'(2);
      if (s1_valid_ff) begin
         space_need = space_need + (hcbp_pkg::QCNT_W+1)'(2);
      end
   end
   assign req_chan.ready = (space_need <= (hcbp_pkg::QCNT_W+1)'(hcbp_pkg::QUEUE_DEPTH));

   // Saturate the length to the cap and drop code bits above it
   always_comb begin
      load_len = req_chan.code_length;
      if (load_len > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LEN_CAP)) begin
         load_len = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LEN_CAP);
      end
      load_code = req_chan.code_value & ~({hcbp_pkg::CODE_W{1'b1}} << load_len);
   end

   // Loads write at accept, so an encode in the next cycle reads the new entry
   always_ff @(posedge clock) begin
      if (req_accept && (req_op == hcbp_pkg::OP_LOAD) && sym_in_range) begin
         code_mem[req_addr] <= {load_len, load_code};
      end
      mem_rd_ff <= code_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (req_accept && (req_op == hcbp_pkg::OP_LOAD) && sym_in_range) begin
         entry_valid_ff[req_addr] <= 1'b1;
      end
   end

   // Only encodes and flushes reach the pack stage; loads and the unused code drop
   assign s1_valid_in = req_accept &&
                        ((req_op == hcbp_pkg::OP_ENCODE) || (req_op == hcbp_pkg::OP_FLUSH));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff  <= req_op;
      s1_hit_ff <= sym_in_range && entry_valid_ff[req_addr];
   end

   // ------------------------------------------------------------------
   // Pack stage: append code to pending bits and split off whole bytes, flag unknown
   // symbols, pad the pending bits out on a flush
   logic [hcbp_pkg::LEN_W-1:0]   s1_len;
   logic [hcbp_pkg::CODE_W-1:0]  s1_code;
   logic [hcbp_pkg::ACC_W-1:0]   acc;
   logic [hcbp_pkg::TOTAL_W-1:0] total;
   logic [hcbp_pkg::PAD_W-1:0]   flush_pad;

   assign s1_len  = mem_rd_ff[hcbp_pkg::ENTRY_W-1 -: hcbp_pkg::LEN_W];
   assign s1_code = mem_rd_ff[hcbp_pkg::CODE_W-1:0];

   always_comb begin
      acc       = (hcbp_pkg::ACC_W'(pend_bits_ff) << s1_len) | hcbp_pkg::ACC_W'(s1_code);
      total     = hcbp_pkg::TOTAL_W'(pend_cnt_ff) + hcbp_pkg::TOTAL_W'(s1_len);
      flush_pad = hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W) - hcbp_pkg::PAD_W'(pend_cnt_ff);

      push_n       = 2'd0;
      push0        = '0;
      push1        = '0;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;

      if (s1_valid_ff) begin
         unique case (s1_op_ff)
            hcbp_pkg::OP_ENCODE: begin
               if (!s1_hit_ff) begin
                  // Unknown symbol: flag it, hold the pending bits
                  push_n               = 2'd1;
                  push0.last_of_run    = 1'b1;
                  push0.unknown_symbol = 1'b1;
               end else begin
                  push0.byte_value = hcbp_pkg::BYTE_W'(acc >>
                                     (total - hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)));
                  push1.byte_value = hcbp_pkg::BYTE_W'(acc >>
                                     (total - hcbp_pkg::TOTAL_W'(2 * hcbp_pkg::BYTE_W)));
                  if (total >= hcbp_pkg::TOTAL_W'(2 * hcbp_pkg::BYTE_W)) begin
                     push_n            = 2'd2;
                     push1.last_of_run = 1'b1;
                  end else if (total >= hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)) begin
                     push_n            = 2'd1;
                     push0.last_of_run = 1'b1;
                  end
                  pend_cnt_in  = total[hcbp_pkg::PCNT_W-1:0];
                  pend_bits_in = hcbp_pkg::PEND_W'(acc) &
                                 ~({hcbp_pkg::PEND_W{1'b1}} << pend_cnt_in);
               end
            end
            hcbp_pkg::OP_FLUSH: begin
               // Pad with zeros; an empty accumulator gives a zero byte, pad 8
               push_n            = 2'd1;
               push0.byte_value  = hcbp_pkg::BYTE_W'({1'b0, pend_bits_ff} << flush_pad);
               push0.pad_count   = flush_pad;
               push0.last_of_run = 1'b1;
               pend_bits_in      = '0;
               pend_cnt_in       = '0;
            end
            default: begin
               push_n = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Result queue: up to two pushes and one pop per cycle
   // ------------------------------------------------------------------
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + hcbp_pkg::QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + hcbp_pkg::QPTR_W'(pop);
      count_in  = count_ff + hcbp_pkg::QCNT_W'(push_n) - hcbp_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + hcbp_pkg::QPTR_W'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.byte_value     = queue_ff[rd_ptr_ff].byte_value;
   assign rsp_chan.pad_count      = queue_ff[rd_ptr_ff].pad_count;
   assign rsp_chan.last_of_run    = queue_ff[rd_ptr_ff].last_of_run;
   assign rsp_chan.unknown_symbol = queue_ff[rd_ptr_ff].unknown_symbol;

`ifndef SYNTHESIS
   // Admission control must keep every push inside the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, count_ff} + (hcbp_pkg::QCNT_W+1)'(push_n)) <=
       (hcbp_pkg::QCNT_W+1)'(hcbp_pkg::QUEUE_DEPTH)))
      else $error("result queue overflow");

   // The pack stage only holds work that entered on the previous edge
   a_stage_origin: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_accept))
      else $error("pack stage valid without an accepted item");

   // A flush always leaves the accumulator empty
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == hcbp_pkg::OP_FLUSH)) |=> (pend_cnt_ff == '0))
      else $error("pending bits survive a flush");
`endif

endmodule
